### design/pgfp_pkg.sv
`default_nettype none
package pgfp_pkg;

	localparam int QUAD_STEPS = 256;
	localparam int GAIN_FRAC_BITS = 15;
	localparam int CORDIC_ITERS = 16;
	localparam int VEC_W = 27;
	localparam int ANG_W = 20;
	localparam int ROT_W = 33;

	localparam logic signed [ANG_W-1:0] ANG_PI = 20'sd205887;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;
	localparam logic signed [ANG_W:0] ANG_TWO_PI = 21'sd411775;
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	localparam logic [15:0] GAIN_ONE = 16'd32768;

	typedef logic signed [ANG_W-1:0] atan_tab_t [CORDIC_ITERS];
	localparam atan_tab_t ATAN_TAB = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2
	};

	// vectoring stage payload
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic [1:0] quad;
		logic kzero;
	} vec_t;

	// rotation stage payload
	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic swap;
	} rot_t;

	// round half up from q30, clamp to 0..1.0
	function automatic logic [15:0] to_gain(input logic signed [ROT_W-1:0] v);
		logic signed [ROT_W:0] sum;
		logic signed [ROT_W:0] r;
		logic [15:0] g;
		sum = {v[ROT_W-1], v} + (ROT_W+1)'(1 << (29 - GAIN_FRAC_BITS));
		r = sum >>> (30 - GAIN_FRAC_BITS);
		if (r < 0) begin
			g = '0;
		end else if (r > (ROT_W+1)'(1 << GAIN_FRAC_BITS)) begin
			g = GAIN_ONE;
		end else begin
			g = r[15:0];
		end
		return g;
	endfunction

endpackage
`default_nettype wire

### design/pgfp_vec_cell.sv
`default_nettype none
module pgfp_vec_cell
	import pgfp_pkg::*;
#(
	parameter int ITER = 0
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_valid,
	input  vec_t in_d,
	output logic out_valid,
	output vec_t out_d
);

	vec_t nxt;

	// one vectoring step towards y = 0
	always_comb begin
		nxt = in_d;
		if (in_d.y > 0) begin
			nxt.x = in_d.x + (in_d.y >>> ITER);
			nxt.y = in_d.y - (in_d.x >>> ITER);
			nxt.z = in_d.z + ATAN_TAB[ITER];
		end else begin
			nxt.x = in_d.x - (in_d.y >>> ITER);
			nxt.y = in_d.y + (in_d.x >>> ITER);
			nxt.z = in_d.z - ATAN_TAB[ITER];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule
`default_nettype wire

### design/pgfp_rot_cell.sv
`default_nettype none
module pgfp_rot_cell
	import pgfp_pkg::*;
#(
	parameter int ITER = 0
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_valid,
	input  rot_t in_d,
	output logic out_valid,
	output rot_t out_d
);

	rot_t nxt;

	// one rotation step towards z = 0
	always_comb begin
		nxt = in_d;
		if (in_d.z >= 0) begin
			nxt.x = in_d.x - (in_d.y >>> ITER);
			nxt.y = in_d.y + (in_d.x >>> ITER);
			nxt.z = in_d.z - ATAN_TAB[ITER];
		end else begin
			nxt.x = in_d.x + (in_d.y >>> ITER);
			nxt.y = in_d.y - (in_d.x >>> ITER);
			nxt.z = in_d.z + ATAN_TAB[ITER];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule
`default_nettype wire

### design/pan_gain_from_position_unit.sv
// Pan gain unit: turns a source position on a ring of 1024 steps into
// constant-power speaker gains.
// Input channel s_axis: one item per position, tdata[9:0] = position.
// Output channel m_axis: one item per input item, tdata holds left_gain,
// right_gain and center_gain, each unsigned Q1.15.
// Configuration: cfg_we with cfg_wdata sets speaker_mode (0 mono, 1 stereo);
// reset selects stereo. Write only while the unit holds no items.
// The pipeline holds an input register, 16 arctangent cells, one angle
// stage, 16 cosine/sine cells and the output register.
// Throughput is one item per cycle while the receiver keeps up; every cell is
// a single CORDIC iteration and the whole row moves together.
// When the receiver stalls with a result waiting, the whole row holds,
// bubbles included, and s_axis_tready drops until the result is taken.
// Reset clears all valid flags, so no item survives a reset.
`default_nettype none
module pan_gain_from_position_unit
	import pgfp_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [9:0] position
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata    // left_gain, right_gain, center_gain
);

	logic mode_q;
	logic en;
	logic vec_v [0:CORDIC_ITERS];
	vec_t vec_d [0:CORDIC_ITERS];
	logic rot_v [0:CORDIC_ITERS];
	rot_t rot_d [0:CORDIC_ITERS];
	vec_t in_nxt;
	rot_t ang_nxt;
	logic signed [ANG_W-1:0] a;
	logic signed [ANG_W-1:0] theta;
	logic signed [ANG_W:0] th_w;
	logic signed [ANG_W:0] al_w;
	logic [15:0] left_g;
	logic [15:0] right_g;
	logic [15:0] centre_g;

	// row advances unless a result is waiting unseen
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// split position into quadrant and step
	always_comb begin
		in_nxt.quad = s_axis_tdata[9:8];
		in_nxt.kzero = (s_axis_tdata[7:0] == 8'd0);
		in_nxt.x = VEC_W'((QUAD_STEPS - int'(s_axis_tdata[7:0])) << 16);
		in_nxt.y = VEC_W'(int'(s_axis_tdata[7:0]) << 16);
		in_nxt.z = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_v[0] <= 1'b0;
		end else if (en) begin
			vec_v[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_d[0] <= in_nxt;
		end
	end

	// arctangent cells
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_vec
		pgfp_vec_cell #(.ITER(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(vec_v[i]), .in_d(vec_d[i]),
			.out_valid(vec_v[i+1]), .out_d(vec_d[i+1])
		);
	end

	// quadrant offset and half angle for the speaker pair
	always_comb begin
		a = vec_d[CORDIC_ITERS].kzero ? '0 : vec_d[CORDIC_ITERS].z;
		case (vec_d[CORDIC_ITERS].quad)
			2'd0:    theta = a;
			2'd1:    theta = a + ANG_HALF_PI;
			2'd2:    theta = a - ANG_PI;
			default: theta = a - ANG_HALF_PI;
		endcase
		ang_nxt.x = CORDIC_GAIN_Q30;
		ang_nxt.y = '0;
		if (theta >= -ANG_HALF_PI && theta < ANG_HALF_PI) begin
			ang_nxt.swap = 1'b0;
			th_w = (ANG_W+1)'(theta);
			al_w = (th_w + ANG_HALF_PI) >>> 1;
		end else begin
			ang_nxt.swap = 1'b1;
			th_w = (theta < -ANG_HALF_PI) ? (ANG_W+1)'(theta) + ANG_TWO_PI
				: (ANG_W+1)'(theta);
			al_w = (th_w - ANG_HALF_PI) >>> 1;
		end
		ang_nxt.z = al_w[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v[0] <= 1'b0;
		end else if (en) begin
			rot_v[0] <= vec_v[CORDIC_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_d[0] <= ang_nxt;
		end
	end

	// cosine and sine cells
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
		pgfp_rot_cell #(.ITER(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(rot_v[i]), .in_d(rot_d[i]),
			.out_valid(rot_v[i+1]), .out_d(rot_d[i+1])
		);
	end

	// gain rounding and speaker mapping
	always_comb begin
		if (!mode_q) begin
			left_g = '0;
			right_g = '0;
			centre_g = GAIN_ONE;
		end else if (rot_d[CORDIC_ITERS].swap) begin
			left_g = to_gain(rot_d[CORDIC_ITERS].y);
			right_g = to_gain(rot_d[CORDIC_ITERS].x);
			centre_g = '0;
		end else begin
			left_g = to_gain(rot_d[CORDIC_ITERS].x);
			right_g = to_gain(rot_d[CORDIC_ITERS].y);
			centre_g = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= rot_v[CORDIC_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {centre_g, right_g, left_g};
		end
	end

	// stalls come only from a waiting result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid) else $error("stall without result");
	// mono gives only the centre gain
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !mode_q) |-> (m_axis_tdata[47:32] == GAIN_ONE &&
		m_axis_tdata[31:0] == 32'd0)) else $error("mono gains wrong");
	// stereo gains never exceed unity and centre is silent
	a_stereo: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && mode_q) |-> (m_axis_tdata[47:32] == 16'd0 &&
		m_axis_tdata[15:0] <= GAIN_ONE && m_axis_tdata[31:16] <= GAIN_ONE))
		else $error("stereo gains wrong");

endmodule
`default_nettype wire
